// ===== hdl/chacha20_stream_cipher_xor_assert.svh =====
// Assertion macros for the ChaCha20 keystream XOR block.
// Each use stands on a line of its own and names the clock and the active-low reset.
`ifndef CHACHA20_STREAM_CIPHER_XOR_ASSERT_SVH
`define CHACHA20_STREAM_CIPHER_XOR_ASSERT_SVH

// Same-cycle implication.
`define CC20X_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("cc20x: same-cycle check failed");

// Next-cycle implication.
`define CC20X_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("cc20x: next-cycle check failed");

`endif

// ===== hdl/cc20x_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cc20x_pkg
// Shared types, constants and helpers of the ChaCha20 keystream XOR block.
// ----------------------------------------------------------------------------
package cc20x_pkg;

    localparam int WORDS         = 16;
    localparam int LANES         = 4;
    localparam int DOUBLE_ROUNDS = 10;
    localparam int ROUND_W       = $clog2(DOUBLE_ROUNDS);
    localparam int POS_W         = $clog2(WORDS);
    localparam int KEY_REGS      = 4;

    typedef logic [31:0] word_t;
    typedef logic [WORDS-1:0][31:0] block_t;
    typedef logic [KEY_REGS-1:0][63:0] key_t;

    // "expand 32-byte k"
    localparam word_t SIGMA_0 = 32'h61707865;
    localparam word_t SIGMA_1 = 32'h3320646e;
    localparam word_t SIGMA_2 = 32'h79622d32;
    localparam word_t SIGMA_3 = 32'h6b206574;

    typedef enum logic [2:0] {
        CFG_KEY_01 = 3'd0,
        CFG_KEY_23 = 3'd1,
        CFG_KEY_45 = 3'd2,
        CFG_KEY_67 = 3'd3,
        CFG_SALT   = 3'd4,
        CFG_IV     = 3'd5
    } cfg_index_t;

    // Quarter-round sub-steps: x += y; z = rotl(z ^ x, n)
    typedef enum logic [1:0] {
        QR_STEP_AD16 = 2'd0,
        QR_STEP_CB12 = 2'd1,
        QR_STEP_AD8  = 2'd2,
        QR_STEP_CB7  = 2'd3
    } qr_step_t;

    localparam logic [1:0] ROLE_A = 2'd0;
    localparam logic [1:0] ROLE_B = 2'd1;
    localparam logic [1:0] ROLE_C = 2'd2;
    localparam logic [1:0] ROLE_D = 2'd3;

    typedef enum logic [1:0] {
        CORE_IDLE  = 2'd0,
        CORE_ROUND = 2'd1,
        CORE_DONE  = 2'd2
    } core_state_t;

    typedef enum logic [1:0] {
        TOP_IDLE = 2'd0,
        TOP_GEN  = 2'd1,
        TOP_XOR  = 2'd2
    } top_state_t;

    // State word index of a quarter-round role for one lane.
    // Column rounds use lane j in every row; diagonal rounds shift row r by r.
    function automatic logic [3:0] qr_word(input logic [1:0] lane, input logic diag,
                                           input logic [1:0] role);
        logic [1:0] col;
        col = diag ? 2'(lane + role) : lane;
        return {role, col};
    endfunction

endpackage

// ===== hdl/cc20x_qr_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cc20x_qr_lane
// One quarter-round sub-step: add, xor and rotate by the step's amount.
// ----------------------------------------------------------------------------
module cc20x_qr_lane (
    input  cc20x_pkg::word_t    x_in,
    input  cc20x_pkg::word_t    y_in,
    input  cc20x_pkg::word_t    z_in,
    input  cc20x_pkg::qr_step_t step,
    output cc20x_pkg::word_t    x_out,
    output cc20x_pkg::word_t    z_out
);

    cc20x_pkg::word_t mix;

    assign x_out = x_in + y_in;
    assign mix   = z_in ^ x_out;

    always_comb begin
        unique case (step)
            cc20x_pkg::QR_STEP_AD16: z_out = {mix[15:0], mix[31:16]};
            cc20x_pkg::QR_STEP_CB12: z_out = {mix[19:0], mix[31:20]};
            cc20x_pkg::QR_STEP_AD8:  z_out = {mix[23:0], mix[31:24]};
            cc20x_pkg::QR_STEP_CB7:  z_out = {mix[24:0], mix[31:25]};
            default:                 z_out = mix;
        endcase
    end

endmodule

// ===== hdl/cc20x_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cc20x_core
// Block function: four shared quarter-round lanes stepped 80 times, then
// the feed-forward add.
// ----------------------------------------------------------------------------
module cc20x_core (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  cc20x_pkg::key_t      key_words,
    input  cc20x_pkg::word_t     salt,
    input  logic [63:0]          iv,
    input  cc20x_pkg::word_t     counter,
    output logic                 done,
    output cc20x_pkg::block_t    block
);

    cc20x_pkg::core_state_t         state_reg, state_next;
    cc20x_pkg::qr_step_t            step_reg, step_next;
    logic                           diag_reg, diag_next;
    logic [cc20x_pkg::ROUND_W-1:0]  round_reg, round_next;
    cc20x_pkg::block_t              w_reg, w_next;
    cc20x_pkg::block_t              init;

    logic [3:0]        x_idx [cc20x_pkg::LANES];
    logic [3:0]        z_idx [cc20x_pkg::LANES];
    cc20x_pkg::word_t  lane_x [cc20x_pkg::LANES];
    cc20x_pkg::word_t  lane_y [cc20x_pkg::LANES];
    cc20x_pkg::word_t  lane_z [cc20x_pkg::LANES];
    cc20x_pkg::word_t  lane_xo [cc20x_pkg::LANES];
    cc20x_pkg::word_t  lane_zo [cc20x_pkg::LANES];

    always_comb begin
        init[0] = cc20x_pkg::SIGMA_0;
        init[1] = cc20x_pkg::SIGMA_1;
        init[2] = cc20x_pkg::SIGMA_2;
        init[3] = cc20x_pkg::SIGMA_3;
        for (int i = 0; i < cc20x_pkg::KEY_REGS; i++) begin
            init[4 + 2 * i] = key_words[i][31:0];
            init[5 + 2 * i] = key_words[i][63:32];
        end
        init[12] = counter;
        init[13] = salt;
        init[14] = iv[31:0];
        init[15] = iv[63:32];
    end

    // operand selection for the lanes
    always_comb begin
        logic       ad_step;
        logic [3:0] y_idx;
        ad_step = (step_reg == cc20x_pkg::QR_STEP_AD16) || (step_reg == cc20x_pkg::QR_STEP_AD8);
        for (int l = 0; l < cc20x_pkg::LANES; l++) begin
            x_idx[l] = cc20x_pkg::qr_word(2'(l), diag_reg,
                                          ad_step ? cc20x_pkg::ROLE_A : cc20x_pkg::ROLE_C);
            y_idx    = cc20x_pkg::qr_word(2'(l), diag_reg,
                                          ad_step ? cc20x_pkg::ROLE_B : cc20x_pkg::ROLE_D);
            z_idx[l] = cc20x_pkg::qr_word(2'(l), diag_reg,
                                          ad_step ? cc20x_pkg::ROLE_D : cc20x_pkg::ROLE_B);
            lane_x[l] = w_reg[x_idx[l]];
            lane_y[l] = w_reg[y_idx];
            lane_z[l] = w_reg[z_idx[l]];
        end
    end

    for (genvar g = 0; g < cc20x_pkg::LANES; g++) begin : g_lane
        cc20x_qr_lane u_lane (
            .x_in  (lane_x[g]),
            .y_in  (lane_y[g]),
            .z_in  (lane_z[g]),
            .step  (step_reg),
            .x_out (lane_xo[g]),
            .z_out (lane_zo[g])
        );
    end

    // feed-forward add, valid while done is high
    always_comb begin
        for (int i = 0; i < cc20x_pkg::WORDS; i++) begin
            block[i] = w_reg[i] + init[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= cc20x_pkg::CORE_IDLE;
            step_reg  <= cc20x_pkg::QR_STEP_AD16;
            diag_reg  <= 1'b0;
            round_reg <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
            diag_reg  <= diag_next;
            round_reg <= round_next;
        end
        w_reg <= w_next;
    end

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        diag_next  = diag_reg;
        round_next = round_reg;
        w_next     = w_reg;
        done       = 1'b0;
        unique case (state_reg)
            cc20x_pkg::CORE_IDLE: begin
                if (start) begin
                    w_next     = init;
                    step_next  = cc20x_pkg::QR_STEP_AD16;
                    diag_next  = 1'b0;
                    round_next = '0;
                    state_next = cc20x_pkg::CORE_ROUND;
                end
            end
            cc20x_pkg::CORE_ROUND: begin
                for (int l = 0; l < cc20x_pkg::LANES; l++) begin
                    w_next[x_idx[l]] = lane_xo[l];
                    w_next[z_idx[l]] = lane_zo[l];
                end
                step_next = cc20x_pkg::qr_step_t'(2'(step_reg + 2'd1));
                if (step_reg == cc20x_pkg::QR_STEP_CB7) begin
                    diag_next = !diag_reg;
                    if (diag_reg) begin
                        round_next = round_reg + 1'b1;
                        if (round_reg == cc20x_pkg::ROUND_W'(cc20x_pkg::DOUBLE_ROUNDS - 1)) begin
                            state_next = cc20x_pkg::CORE_DONE;
                        end
                    end
                end
            end
            cc20x_pkg::CORE_DONE: begin
                done       = 1'b1;
                state_next = cc20x_pkg::CORE_IDLE;
            end
            default: begin
                state_next = cc20x_pkg::CORE_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/chacha20_stream_cipher_xor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chacha20_stream_cipher_xor
// ChaCha20 keystream XOR, one 32-bit data word per item.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries message words (valid/ready); m_* returns the XORed words in
//   order, one per input item. cfg_* writes key, salt and IV registers by
//   index; cfg_ready is always high. Write them only while no item is open.
//   Words at position 1..15 of a block go straight to the XOR state, then
//   out through the output register. A word at position 0 first runs the
//   block function (four quarter-round lanes, one add/xor/rotate sub-step
//   per cycle through 10 double rounds, a load before, a feed-forward add
//   after) before it goes the same way.
//   s_ready is low while a word is being processed; the next item is taken
//   while the previous result still sits in the output register.
//   A stalled receiver holds m_* steady; the block then waits with the
//   next result until the output register frees up.
//   Reset clears key, salt, IV and the output valid, sets the block counter
//   to 1 and the word position to 0. A last word returns both to those values.
// ----------------------------------------------------------------------------
`include "chacha20_stream_cipher_xor_assert.svh"

module chacha20_stream_cipher_xor (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_data_word,
    input  logic [2:0]  s_byte_count,
    input  logic        s_is_last,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_out_word,
    output logic [2:0]  m_out_byte_count,
    output logic        m_out_last
);

    cc20x_pkg::top_state_t          state_reg, state_next;
    cc20x_pkg::key_t                key_reg, key_next;
    cc20x_pkg::word_t               salt_reg, salt_next;
    logic [63:0]                    iv_reg, iv_next;
    cc20x_pkg::word_t               counter_reg, counter_next;
    logic [cc20x_pkg::POS_W-1:0]    pos_reg, pos_next;
    cc20x_pkg::block_t              ks_buf_reg, ks_buf_next;

    cc20x_pkg::word_t   data_reg, data_next;
    logic [2:0]         count_reg, count_next;
    logic               last_reg, last_next;

    logic               m_valid_reg, m_valid_next;
    cc20x_pkg::word_t   m_word_reg, m_word_next;
    logic [2:0]         m_count_reg, m_count_next;
    logic               m_last_reg, m_last_next;

    logic               in_accept;
    logic               out_load;
    logic               core_start;
    logic               core_done;
    cc20x_pkg::block_t  core_block;
    cc20x_pkg::word_t   mask;

    assign cfg_ready  = 1'b1;
    assign s_ready    = (state_reg == cc20x_pkg::TOP_IDLE);
    assign in_accept  = s_valid && s_ready;
    assign core_start = in_accept && (pos_reg == '0);

    assign m_valid          = m_valid_reg;
    assign m_out_word       = m_word_reg;
    assign m_out_byte_count = m_count_reg;
    assign m_out_last       = m_last_reg;

    cc20x_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (core_start),
        .key_words (key_reg),
        .salt      (salt_reg),
        .iv        (iv_reg),
        .counter   (counter_reg),
        .done      (core_done),
        .block     (core_block)
    );

    // configuration writes
    always_comb begin
        key_next  = key_reg;
        salt_next = salt_reg;
        iv_next   = iv_reg;
        if (cfg_valid && cfg_ready) begin
            unique case (cc20x_pkg::cfg_index_t'(cfg_index))
                cc20x_pkg::CFG_KEY_01: key_next[0] = cfg_data;
                cc20x_pkg::CFG_KEY_23: key_next[1] = cfg_data;
                cc20x_pkg::CFG_KEY_45: key_next[2] = cfg_data;
                cc20x_pkg::CFG_KEY_67: key_next[3] = cfg_data;
                cc20x_pkg::CFG_SALT:   salt_next   = cfg_data[31:0];
                cc20x_pkg::CFG_IV:     iv_next     = cfg_data;
                default: ;
            endcase
        end
    end

    // byte mask from the valid byte count; counts above four act as four
    always_comb begin
        unique case (count_reg)
            3'd0:    mask = 32'h0000_0000;
            3'd1:    mask = 32'h0000_00ff;
            3'd2:    mask = 32'h0000_ffff;
            3'd3:    mask = 32'h00ff_ffff;
            default: mask = 32'hffff_ffff;
        endcase
    end

    assign out_load = (state_reg == cc20x_pkg::TOP_XOR) && (!m_valid_reg || m_ready);

    always_comb begin
        state_next   = state_reg;
        counter_next = counter_reg;
        pos_next     = pos_reg;
        ks_buf_next  = ks_buf_reg;
        data_next    = data_reg;
        count_next   = count_reg;
        last_next    = last_reg;
        m_word_next  = m_word_reg;
        m_count_next = m_count_reg;
        m_last_next  = m_last_reg;
        m_valid_next = m_valid_reg && !m_ready;

        unique case (state_reg)
            cc20x_pkg::TOP_IDLE: begin
                if (in_accept) begin
                    data_next  = s_data_word;
                    count_next = s_byte_count;
                    last_next  = s_is_last;
                    state_next = (pos_reg == '0) ? cc20x_pkg::TOP_GEN : cc20x_pkg::TOP_XOR;
                end
            end
            cc20x_pkg::TOP_GEN: begin
                if (core_done) begin
                    ks_buf_next  = core_block;
                    counter_next = counter_reg + 32'd1;
                    state_next   = cc20x_pkg::TOP_XOR;
                end
            end
            cc20x_pkg::TOP_XOR: begin
                if (out_load) begin
                    m_valid_next = 1'b1;
                    m_word_next  = (data_reg ^ ks_buf_reg[pos_reg]) & mask;
                    m_count_next = count_reg;
                    m_last_next  = last_reg;
                    state_next   = cc20x_pkg::TOP_IDLE;
                    if (last_reg) begin
                        pos_next     = '0;
                        counter_next = 32'd1;
                    end else begin
                        pos_next = pos_reg + 1'b1;
                    end
                end
            end
            default: begin
                state_next = cc20x_pkg::TOP_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= cc20x_pkg::TOP_IDLE;
            key_reg     <= '0;
            salt_reg    <= '0;
            iv_reg      <= '0;
            counter_reg <= 32'd1;
            pos_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            key_reg     <= key_next;
            salt_reg    <= salt_next;
            iv_reg      <= iv_next;
            counter_reg <= counter_next;
            pos_reg     <= pos_next;
            m_valid_reg <= m_valid_next;
        end
        ks_buf_reg  <= ks_buf_next;
        data_reg    <= data_next;
        count_reg   <= count_next;
        last_reg    <= last_next;
        m_word_reg  <= m_word_next;
        m_count_reg <= m_count_next;
        m_last_reg  <= m_last_next;
    end

    // a finished block only shows up while the item waits for it
    `CC20X_ASSERT_IMPL(a_done_in_gen, aclk, aresetn, core_done, state_reg == cc20x_pkg::TOP_GEN)
    // a word at a block boundary always runs the block function
    `CC20X_ASSERT_NEXT(a_boundary_gen, aclk, aresetn, core_start, state_reg == cc20x_pkg::TOP_GEN)
    // mid-block words skip straight to the XOR
    `CC20X_ASSERT_NEXT(a_mid_xor, aclk, aresetn, in_accept && (pos_reg != '0), state_reg == cc20x_pkg::TOP_XOR)
    // a result never overwrites one still waiting
    `CC20X_ASSERT_IMPL(a_no_overwrite, aclk, aresetn, out_load, !m_valid_reg || m_ready)

endmodule

// ===== bench/chacha20_stream_cipher_xor_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chacha20_stream_cipher_xor_test
// Self-checking bench for the ChaCha20 keystream XOR block. A short table of
// hand-picked words (byte count extremes, short and one-word messages) is
// followed by random messages under several key/salt/IV settings and three
// idle mixes. Every output word is compared against an in-bench ChaCha20
// keystream predictor that tracks block counter and word position, or against a typed-in word for pinned table rows.
// ----------------------------------------------------------------------------
module chacha20_stream_cipher_xor_test;
    import cc20x_pkg::*;

    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 200;
    localparam int TOTAL_ITEMS  = 1150;
    localparam int SEGMENTS     = 9;

    typedef struct packed {
        word_t      word;
        logic [2:0] count;
        logic       is_last;
    } cipher_out_t;

    typedef struct packed {
        word_t      data;
        logic [2:0] count;
        logic       is_last;
        logic       pinned;      // expected word typed in below
        word_t      pinned_word;
    } probe_row_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [63:0] cfg_data;
    logic        s_valid;
    logic        s_ready;
    logic [31:0] s_data_word;
    logic [2:0]  s_byte_count;
    logic        s_is_last;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_out_word;
    logic [2:0]  m_out_byte_count;
    logic        m_out_last;

    chacha20_stream_cipher_xor dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_data_word      (s_data_word),
        .s_byte_count     (s_byte_count),
        .s_is_last        (s_is_last),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_out_word       (m_out_word),
        .m_out_byte_count (m_out_byte_count),
        .m_out_last       (m_out_last)
    );

    // Predictor state
    logic [63:0] cfg_mirror [6];
    block_t      ks_block;
    logic [3:0]  ks_pos  = '0;
    word_t       blk_ctr = 32'd1;

    cipher_out_t pending_out [$];
    int errors        = 0;
    int items_sent    = 0;
    int words_checked = 0;
    int messages      = 0;
    int blocks_made   = 0;
    int reg_writes    = 0;
    int stall_cycles  = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    // Byte count zero always yields a zero word, whatever the keystream.
    probe_row_t probe_table [11] = '{
        '{32'h00000000, 3'd4, 1'b0, 1'b0, 32'h0},
        '{32'hffffffff, 3'd4, 1'b0, 1'b0, 32'h0},
        '{32'hffffffff, 3'd0, 1'b0, 1'b1, 32'h0},
        '{32'h12345678, 3'd5, 1'b0, 1'b0, 32'h0},
        '{32'ha5a5a5a5, 3'd7, 1'b0, 1'b0, 32'h0},
        '{32'hffffffff, 3'd1, 1'b0, 1'b0, 32'h0},
        '{32'hffffffff, 3'd2, 1'b0, 1'b0, 32'h0},
        '{32'hffffffff, 3'd3, 1'b1, 1'b0, 32'h0},
        '{32'hffffffff, 3'd1, 1'b1, 1'b0, 32'h0},
        '{32'h80000001, 3'd6, 1'b1, 1'b0, 32'h0},
        '{32'hffffffff, 3'd0, 1'b1, 1'b1, 32'h0}
    };

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic word_t rotl(input word_t v, input int n);
        return (v << n) | (v >> (32 - n));
    endfunction

    function automatic logic [127:0] qr_mix(input word_t a, input word_t b,
                                            input word_t c, input word_t d);
        a = a + b; d = rotl(d ^ a, 16);
        c = c + d; b = rotl(b ^ c, 12);
        a = a + b; d = rotl(d ^ a, 8);
        c = c + d; b = rotl(b ^ c, 7);
        return {a, b, c, d};
    endfunction

    function automatic block_t keystream_block(input word_t ctr);
        word_t  init [16];
        word_t  x [16];
        block_t blk;
        init[0] = SIGMA_0;
        init[1] = SIGMA_1;
        init[2] = SIGMA_2;
        init[3] = SIGMA_3;
        for (int i = 0; i < KEY_REGS; i++) begin
            init[4 + 2 * i] = cfg_mirror[i][31:0];
            init[5 + 2 * i] = cfg_mirror[i][63:32];
        end
        init[12] = ctr;
        init[13] = cfg_mirror[CFG_SALT][31:0];
        init[14] = cfg_mirror[CFG_IV][31:0];
        init[15] = cfg_mirror[CFG_IV][63:32];
        x = init;
        for (int r = 0; r < DOUBLE_ROUNDS; r++) begin
            {x[0], x[4], x[8],  x[12]} = qr_mix(x[0], x[4], x[8],  x[12]);
            {x[1], x[5], x[9],  x[13]} = qr_mix(x[1], x[5], x[9],  x[13]);
            {x[2], x[6], x[10], x[14]} = qr_mix(x[2], x[6], x[10], x[14]);
            {x[3], x[7], x[11], x[15]} = qr_mix(x[3], x[7], x[11], x[15]);
            {x[0], x[5], x[10], x[15]} = qr_mix(x[0], x[5], x[10], x[15]);
            {x[1], x[6], x[11], x[12]} = qr_mix(x[1], x[6], x[11], x[12]);
            {x[2], x[7], x[8],  x[13]} = qr_mix(x[2], x[7], x[8],  x[13]);
            {x[3], x[4], x[9],  x[14]} = qr_mix(x[3], x[4], x[9],  x[14]);
        end
        for (int i = 0; i < WORDS; i++)
            blk[i] = x[i] + init[i];
        return blk;
    endfunction

    function automatic cipher_out_t predict_word(input word_t data, input logic [2:0] count,
                                                 input logic is_last);
        cipher_out_t res;
        word_t       mask;
        int          nbytes;
        nbytes = (count > 3'd4) ? 4 : int'(count);
        if (ks_pos == 4'd0) begin
            ks_block = keystream_block(blk_ctr);
            blk_ctr = blk_ctr + 32'd1;
            blocks_made++;
        end
        mask = (nbytes == 4) ? '1 : ((32'd1 << (8 * nbytes)) - 32'd1);
        res.word    = (data ^ ks_block[ks_pos]) & mask;
        res.count   = count;
        res.is_last = is_last;
        if (is_last) begin
            ks_pos  = '0;
            blk_ctr = 32'd1;
        end else begin
            ks_pos = ks_pos + 4'd1;
        end
        return res;
    endfunction

    task automatic check_result();
        cipher_out_t want;
        if (pending_out.size() == 0) begin
            $display("%0t: unexpected output word %h, nothing pending", $time, m_out_word);
            errors++;
            return;
        end
        want = pending_out.pop_front();
        words_checked++;
        if (m_out_word !== want.word) begin
            $display("%0t: out_word mismatch: expected %h, got %h", $time, want.word,
                     m_out_word);
            errors++;
        end
        if (m_out_byte_count !== want.count) begin
            $display("%0t: out_byte_count mismatch: expected %0d, got %0d", $time,
                     want.count, m_out_byte_count);
            errors++;
        end
        if (m_out_last !== want.is_last) begin
            $display("%0t: out_last mismatch: expected %b, got %b", $time, want.is_last,
                     m_out_last);
            errors++;
        end
    endtask

    // Output side: checking, random backpressure and the stall watchdog.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            check_result();
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
            $display("[chacha20_stream_cipher_xor] ERROR");
            $finish;
        end
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic send_word(input word_t data, input logic [2:0] count, input logic is_last,
                             input logic pinned, input word_t pinned_word);
        int          gap;
        cipher_out_t want;
        gap = 0;
        while (gap < 40 && $urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_data_word  <= data;
        s_byte_count <= count;
        s_is_last    <= is_last;
        do @(posedge aclk); while (!s_ready);
        want = predict_word(data, count, is_last);
        if (pinned)
            want.word = pinned_word;
        pending_out.push_back(want);
        items_sent++;
        if (is_last)
            messages++;
    endtask

    // Hold off input until every pending word has come back.
    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_out.size() != 0);
    endtask

    // Leaves cfg_valid high; the caller lowers it after its last write.
    task automatic put_reg(input cfg_index_t idx, input logic [63:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_mirror[idx] = (idx == CFG_SALT) ? {32'h0, val[31:0]} : val;
        reg_writes++;
    endtask

    task automatic program_regs(input key_t key, input logic [63:0] salt,
                                input logic [63:0] iv);
        put_reg(CFG_KEY_01, key[0]);
        put_reg(CFG_KEY_23, key[1]);
        put_reg(CFG_KEY_45, key[2]);
        put_reg(CFG_KEY_67, key[3]);
        put_reg(CFG_SALT, salt);
        put_reg(CFG_IV, iv);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_message(input int len, input bit noisy);
        int         rekey_at;
        word_t      data;
        logic [2:0] count;
        logic       is_last;
        rekey_at = (len > 1 && $urandom_range(7) == 0) ? $urandom_range(1, len - 1) : -1;
        for (int i = 0; i < len; i++) begin
            is_last = (i == len - 1);
            count = is_last ? 3'($urandom_range(1, 4)) : 3'd4;
            if (noisy && $urandom_range(3) == 0)
                count = 3'($urandom_range(0, 7));
            case ($urandom_range(9))
                0:       data = '0;
                1:       data = '1;
                default: data = $urandom;
            endcase
            // register change inside a message: only the next block sees it
            if (i == rekey_at) begin
                drain();
                put_reg(cfg_index_t'($urandom_range(5)), {$urandom, $urandom});
                cfg_valid <= 1'b0;
            end
            send_word(data, count, is_last, 1'b0, '0);
        end
    endtask

    initial begin
        int   len;
        key_t key;
        for (int i = 0; i < 6; i++)
            cfg_mirror[i] = '0;
        aresetn      <= 1'b0;
        cfg_valid    <= 1'b0;
        cfg_index    <= CFG_KEY_01;
        cfg_data     <= '0;
        s_valid      <= 1'b0;
        s_data_word  <= '0;
        s_byte_count <= '0;
        s_is_last    <= 1'b0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // directed words under the all-zero reset registers
        send_idle_pct = 30;
        recv_idle_pct = 68;
        foreach (probe_table[i])
            send_word(probe_table[i].data, probe_table[i].count, probe_table[i].is_last,
                      probe_table[i].pinned, probe_table[i].pinned_word);
        drain();

        for (int seg = 0; seg < SEGMENTS; seg++) begin
            case (seg / 3)
                0: begin send_idle_pct = 30; recv_idle_pct = 68; end
                1: begin send_idle_pct = 68; recv_idle_pct = 30; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            case (seg)
                0: program_regs('1, '1, '1);
                1: program_regs('0, '0, '0);
                2: begin
                    // key bytes 00..1f, salt and IV in the usual test layout
                    for (int k = 0; k < KEY_REGS; k++)
                        key[k] = {8'(8*k+7), 8'(8*k+6), 8'(8*k+5), 8'(8*k+4),
                                  8'(8*k+3), 8'(8*k+2), 8'(8*k+1), 8'(8*k)};
                    program_regs(key, 64'h09000000, 64'h4a000000);
                end
                default: begin
                    for (int k = 0; k < KEY_REGS; k++)
                        key[k] = {$urandom, $urandom};
                    program_regs(key, {$urandom, $urandom}, {$urandom, $urandom});
                end
            endcase
            while (items_sent < $size(probe_table) + (seg + 1) * (TOTAL_ITEMS / SEGMENTS)) begin
                if ($urandom_range(19) == 0)
                    drain();
                case ($urandom_range(19))
                    0:       len = $urandom_range(51, 70);
                    1, 2, 3: len = $urandom_range(17, 50);
                    default: len = $urandom_range(1, 16);
                endcase
                send_message(len, $urandom_range(4) == 0);
            end
            drain();
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (pending_out.size() != 0) begin
            $display("%0t: %0d words never came back", $time, pending_out.size());
            errors++;
        end
        $display("%0d words in %0d messages checked, %0d keystream blocks, %0d reg writes",
                 words_checked, messages, blocks_made, reg_writes);
        $display("keys: reset, all ones, all zero, byte sequence, random; counts 0..7");
        if (errors == 0)
            $display("[chacha20_stream_cipher_xor] OK");
        else
            $display("[chacha20_stream_cipher_xor] ERROR");
        $finish;
    end

endmodule
